// File: rtl/mdrs_pkg.sv
`timescale 1ns / 1ps
// Package for the Markov DNA read scorer: default parameters, opcodes and
// the packed transfer types of the input and result channels.
// Depends on nothing.
package mdrs_pkg;

  localparam int unsigned DefOrder       = 6;
  localparam int unsigned DefScoreWidth  = 24;
  localparam int unsigned DefMaxReadLen  = 65536;

  localparam int unsigned AddrWidth  = 15;
  localparam int unsigned ValueWidth = 24;
  localparam int unsigned SumWidth   = 48;
  localparam int unsigned RowWidth   = 3;

  localparam logic OpWrite = 1'b0;
  localparam logic OpBase  = 1'b1;

  localparam logic [RowWidth-1:0] RowPrior = '0;

  localparam logic [SumWidth-1:0] SumMax = {1'b0, {(SumWidth - 1){1'b1}}};
  localparam logic [SumWidth-1:0] SumMin = {1'b1, {(SumWidth - 1){1'b0}}};

  typedef struct packed {
    logic                         op;
    logic [AddrWidth-1:0]         table_addr;
    logic signed [ValueWidth-1:0] table_value;
    logic [1:0]                   base;
    logic                         last;
  } in_item_t;

  typedef struct packed {
    logic signed [SumWidth-1:0] read_score;
    logic                       too_short;
  } out_item_t;

endpackage

// File: rtl/mdrs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with the
// read data registered. Read-first when both ports hit the same entry.
module mdrs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/markov_dna_read_scorer.sv
`timescale 1ns / 1ps
// Top level of the Markov DNA read scorer. Depends on mdrs_pkg and mdrs_ram.
// A write transfer stores one log10 score into the table. A base transfer
// needs table reads on the single read port of the score memory: none for
// the first bases of a read, one at the base that completes the first
// context, two (forward and reverse term) for every later base, and one more
// for the reverse start prior on the last base. The input stalls until all
// but the last read of a base are issued, and while the last step of a read
// waits for room in the result registers. The result of a read is registered
// in the final and then the output register. Sums saturate at 48 bits and a
// read shorter than ORDER bases returns a zero score with too_short set.
module markov_dna_read_scorer import mdrs_pkg::*; #(
  parameter int unsigned ORDER        = DefOrder,
  parameter int unsigned SCORE_WIDTH  = DefScoreWidth,
  parameter int unsigned MAX_READ_LEN = DefMaxReadLen
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned CtxWidth   = 2 * ORDER;
  localparam int unsigned WinWidth   = 2 * (ORDER + 1);
  localparam int unsigned RamAw      = RowWidth + CtxWidth;
  localparam int unsigned TableDepth = 5 * (2 ** CtxWidth);
  localparam int unsigned SeenWidth  = $clog2(MAX_READ_LEN + 1);

  localparam int unsigned PendFwd   = 0;
  localparam int unsigned PendRev   = 1;
  localparam int unsigned PendPrior = 2;
  localparam int unsigned PendShort = 3;

  logic                 in_acc;
  logic [WinWidth-1:0]  win_q, win_new;
  logic [SeenWidth-1:0] seen_q, seen_new;
  logic                 n_eq, n_gt;

  logic [WinWidth-1:0]  iss_win_q;
  logic [1:0]           iss_base_q;
  logic                 iss_last_q;
  logic                 iss_fp_q;
  logic [3:0]           pend_q, pick, rem;
  logic                 tok_final, room, issue_go;

  logic [CtxWidth-1:0]  fwd_ctx, rev_ctx;
  logic [RowWidth-1:0]  fwd_row, rev_row;
  logic [RamAw-1:0]     ram_raddr, ram_waddr;
  logic                 ram_re, ram_we;
  logic [31:0]          waddr32;
  logic signed [31:0]   val32;
  logic [SCORE_WIDTH-1:0] ram_rdata;

  logic b_vld_q, b_rev_q, b_final_q, b_short_q;
  logic signed [SCORE_WIDTH-1:0] term_s;
  logic signed [SumWidth-1:0]    term48, acc_in, sat_sum;
  logic signed [SumWidth:0]      sum49;
  logic signed [SumWidth-1:0]    fwd_q, rev_q, fwd_new, rev_new;
  logic                          add_en;

  logic                       fin_vld_q;
  logic signed [SumWidth-1:0] fin_fwd_q, fin_rev_q;
  logic                       fin_short_q;
  logic                       out_vld_q, move;
  out_item_t                  out_data_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign win_new  = {win_q[WinWidth-3:0], in_data_i.base};
  assign seen_new = (seen_q < SeenWidth'(MAX_READ_LEN)) ? seen_q + 1'b1 : seen_q;
  assign n_eq     = seen_new == SeenWidth'(ORDER);
  assign n_gt     = seen_new >= SeenWidth'(ORDER + 1);

  assign pick      = pend_q & (~pend_q + 4'd1);
  assign rem       = pend_q & ~pick;
  assign tok_final = iss_last_q && (rem == '0);
  assign room      = ({1'b0, b_final_q} + {1'b0, fin_vld_q} + {1'b0, out_vld_q}) < 2'd2;
  assign issue_go  = (pend_q != '0) && (!tok_final || room);
  assign in_stall_o = (pend_q != '0) && (!issue_go || (rem != '0));

  always_comb begin
    rev_ctx = '0;
    for (int j = 0; j < ORDER; j++) begin
      rev_ctx[2*(ORDER-1-j) +: 2] = iss_win_q[2*j +: 2] ^ 2'b01;
    end
  end

  assign fwd_ctx = iss_fp_q ? iss_win_q[CtxWidth-1:0] : iss_win_q[CtxWidth+1:2];
  assign fwd_row = iss_fp_q ? RowPrior : RowWidth'(iss_base_q) + RowWidth'(1);
  assign rev_row = RowWidth'(iss_win_q[WinWidth-1 -: 2] ^ 2'b01) + RowWidth'(1);

  always_comb begin
    if (pick[PendFwd]) begin
      ram_raddr = {fwd_row, fwd_ctx};
    end else if (pick[PendRev]) begin
      ram_raddr = {rev_row, rev_ctx};
    end else begin
      ram_raddr = {RowPrior, rev_ctx};
    end
  end

  assign ram_re    = issue_go && !pick[PendShort];
  assign waddr32   = 32'(in_data_i.table_addr);
  assign val32     = 32'(in_data_i.table_value);
  assign ram_waddr = waddr32[RamAw-1:0];
  assign ram_we    = in_acc && (in_data_i.op == OpWrite) && (waddr32 < 32'(TableDepth));

  mdrs_ram #(
    .Width (SCORE_WIDTH),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val32[SCORE_WIDTH-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= '0;
      seen_q     <= '0;
      pend_q     <= '0;
      iss_win_q  <= '0;
      iss_base_q <= '0;
      iss_last_q <= 1'b0;
      iss_fp_q   <= 1'b0;
    end else if (in_acc && (in_data_i.op == OpBase)) begin
      win_q      <= in_data_i.last ? '0 : win_new;
      seen_q     <= in_data_i.last ? '0 : seen_new;
      iss_win_q  <= win_new;
      iss_base_q <= in_data_i.base;
      iss_last_q <= in_data_i.last;
      iss_fp_q   <= n_eq;
      pend_q     <= {in_data_i.last && !(n_eq || n_gt), in_data_i.last && (n_eq || n_gt),
                     n_gt, n_eq || n_gt};
    end else if (issue_go) begin
      pend_q <= rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      b_final_q <= 1'b0;
      b_rev_q   <= 1'b0;
      b_short_q <= 1'b0;
    end else begin
      b_vld_q   <= issue_go;
      b_final_q <= issue_go && tok_final;
      b_rev_q   <= pick[PendRev] || pick[PendPrior];
      b_short_q <= pick[PendShort];
    end
  end

  assign term_s  = ram_rdata;
  assign term48  = SumWidth'(term_s);
  assign acc_in  = b_rev_q ? rev_q : fwd_q;
  assign sum49   = {acc_in[SumWidth-1], acc_in} + {term48[SumWidth-1], term48};
  assign sat_sum = (sum49[SumWidth] != sum49[SumWidth-1]) ?
                   (sum49[SumWidth] ? SumMin : SumMax) : sum49[SumWidth-1:0];
  assign add_en  = b_vld_q && !b_short_q;
  assign fwd_new = (add_en && !b_rev_q) ? sat_sum : fwd_q;
  assign rev_new = (add_en && b_rev_q) ? sat_sum : rev_q;

  assign move = fin_vld_q && (!out_vld_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q     <= '0;
      rev_q     <= '0;
      fin_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (b_final_q) begin
        fwd_q <= '0;
        rev_q <= '0;
      end else begin
        fwd_q <= fwd_new;
        rev_q <= rev_new;
      end
      fin_vld_q <= b_final_q || (fin_vld_q && !move);
      out_vld_q <= move || (out_vld_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_final_q) begin
      fin_fwd_q   <= fwd_new;
      fin_rev_q   <= rev_new;
      fin_short_q <= b_short_q;
    end
    if (move) begin
      out_data_q.too_short  <= fin_short_q;
      out_data_q.read_score <= fin_short_q ? '0 :
                               ((fin_fwd_q > fin_rev_q) ? fin_fwd_q : fin_rev_q);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/mdrs_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the Markov DNA read scorer and its bind statement.
// Depends on mdrs_pkg and on the markov_dna_read_scorer top level.
module mdrs_checker import mdrs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result transfer was withdrawn.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("Stalled result payload changed.");

  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.too_short |-> out_data_o.read_score == '0)
    else $error("Short read reported a nonzero score.");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o && (in_data_i.op == OpBase)))
    else $error("Input stall rose without a base transfer before it.");

endmodule

bind markov_dna_read_scorer mdrs_checker u_mdrs_checker (.*);
